### design/vfcm_pkg.sv
// Shared types and constants of the voxel face culling mesher.
`default_nettype none
package vfcm_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GATHER,
    ST_EMIT
  } state_t;

  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_MESH    = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  localparam int COORD_W    = 4;
  localparam int ID_W       = 8;
  localparam int DIR_W      = 3;
  localparam int VTX_W      = 17;
  localparam int FACE_COUNT = 6;

  localparam logic [VTX_W-1:0] VERTS_PER_FACE = 17'd4;

  localparam logic [DIR_W-1:0] FACE_POS_Z = 3'd0;
  localparam logic [DIR_W-1:0] FACE_NEG_Z = 3'd1;
  localparam logic [DIR_W-1:0] FACE_POS_X = 3'd2;
  localparam logic [DIR_W-1:0] FACE_NEG_X = 3'd3;
  localparam logic [DIR_W-1:0] FACE_POS_Y = 3'd4;
  localparam logic [DIR_W-1:0] FACE_NEG_Y = 3'd5;
  localparam logic [DIR_W-1:0] FACE_DONE  = 3'd6;

endpackage
`default_nettype wire

### design/vfcm_ram.sv
// Generic single-port RAM with a registered read port.
`default_nettype none
module vfcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire  [$clog2(DEPTH)-1:0] addr,
  input  wire  [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

### design/voxel_face_culling_mesher.sv
// Top level of the voxel face culling mesher: block id store and face sequencer.
//
//   channel | direction | tdata (low bit up)                          | tuser     | tlast
//   s_*     | in        | cell_x, cell_y, cell_z, block_id            | operation | -
//   m_*     | out       | face_x, face_y, face_z, face_dir,           | -         | last_face
//           |           | base_vertex, reversed_winding               |           |
//
// Write and restart requests are done when accepted and leave the sequencer idle. A mesh
// request reads the cell and its six neighbours in turn through the single store port,
// then emits the exposed faces one per cycle while the output register drains; it ends
// after the first read on an air cell and at once out of range.
// Reset (rst, synchronous) clears the sequencer, the vertex counter and the output valid;
// the store contents stay undefined until written. A stall on m_tready holds the face
// sequencer, and s_tready is high only while no request is in progress.
`default_nettype none
module voxel_face_culling_mesher #(
  parameter int EDGE_CELLS = 16
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [23:0] s_tdata,   // cell_x, cell_y, cell_z, block_id, zero fill
  input  wire  [1:0]  s_tuser,   // operation
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [39:0] m_tdata,   // face_x, face_y, face_z, face_dir, base_vertex,
                                 // reversed_winding, zero fill
  output logic        m_tlast    // last_face
);
  import vfcm_pkg::*;

  localparam int DEPTH = EDGE_CELLS * EDGE_CELLS * EDGE_CELLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int NW    = COORD_W + 1;

  function automatic logic [AW-1:0] cell_addr(input logic [NW-1:0] x,
                                              input logic [NW-1:0] y,
                                              input logic [NW-1:0] z);
    int idx;
    idx = (int'(z) * EDGE_CELLS + int'(y)) * EDGE_CELLS + int'(x);
    return idx[AW-1:0];
  endfunction

  state_t state, state_next;

  logic [COORD_W-1:0] cx, cy, cz;
  logic [DIR_W-1:0]   step;
  logic [FACE_COUNT-1:0] face_air;
  logic               rd_in;
  logic [VTX_W-1:0]   vertex_counter;

  logic [COORD_W-1:0] face_x, face_y, face_z;
  logic [DIR_W-1:0]   face_dir;
  logic [VTX_W-1:0]   base_vertex;
  logic               reversed_winding;

  logic [COORD_W-1:0] in_x, in_y, in_z;
  logic [ID_W-1:0]    in_id;
  logic [1:0]         in_op;
  logic               in_accept, in_inside;

  logic               ram_we;
  logic [AW-1:0]      ram_addr;
  logic [ID_W-1:0]    ram_rdata;

  logic [NW-1:0]      nb_x, nb_y, nb_z;
  logic               nb_under, nb_in;
  logic               air;
  logic [FACE_COUNT-1:0] gather_mask, mask_rest;
  logic [DIR_W-1:0]   pick;
  logic               slot_free, emit_fire;

  assign in_x  = s_tdata[3:0];
  assign in_y  = s_tdata[7:4];
  assign in_z  = s_tdata[11:8];
  assign in_id = s_tdata[19:12];
  assign in_op = s_tuser;

  assign in_accept = s_tvalid && s_tready;
  assign in_inside = int'(in_x) < EDGE_CELLS && int'(in_y) < EDGE_CELLS &&
                     int'(in_z) < EDGE_CELLS;

  vfcm_ram #(
    .WIDTH (ID_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_id),
    .rdata (ram_rdata)
  );

  // Neighbour of the current cell in the direction of the face being read.
  always_comb begin
    nb_x     = {1'b0, cx};
    nb_y     = {1'b0, cy};
    nb_z     = {1'b0, cz};
    nb_under = 1'b0;
    case (step)
      FACE_POS_Z: nb_z = {1'b0, cz} + 5'd1;
      FACE_NEG_Z: begin
        nb_z     = {1'b0, cz} - 5'd1;
        nb_under = (cz == '0);
      end
      FACE_POS_X: nb_x = {1'b0, cx} + 5'd1;
      FACE_NEG_X: begin
        nb_x     = {1'b0, cx} - 5'd1;
        nb_under = (cx == '0);
      end
      FACE_POS_Y: nb_y = {1'b0, cy} + 5'd1;
      FACE_NEG_Y: begin
        nb_y     = {1'b0, cy} - 5'd1;
        nb_under = (cy == '0);
      end
      default: nb_under = 1'b1;
    endcase
    nb_in = !nb_under && int'(nb_x) < EDGE_CELLS && int'(nb_y) < EDGE_CELLS &&
            int'(nb_z) < EDGE_CELLS;
  end

  // The store data that arrives now belongs to the read issued in the previous cycle.
  assign air = !rd_in || (ram_rdata == '0);

  always_comb begin
    gather_mask = face_air;
    if (step != '0 && air) begin
      gather_mask = face_air | (6'b000001 << (step - 3'd1));
    end
  end

  always_comb begin
    pick = FACE_NEG_Y;
    for (int i = FACE_COUNT - 1; i >= 0; i--) begin
      if (face_air[i]) begin
        pick = DIR_W'(i);
      end
    end
  end

  assign mask_rest = face_air & (face_air - 6'd1);
  assign slot_free = !m_tvalid || m_tready;
  assign emit_fire = (state == ST_EMIT) && slot_free;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_accept && in_op == OP_MESH && in_inside) begin
          state_next = ST_GATHER;
        end
      end
      ST_GATHER: begin
        if (step == '0 && ram_rdata == '0) begin
          state_next = ST_IDLE;
        end else if (step == FACE_DONE) begin
          state_next = (gather_mask == '0) ? ST_IDLE : ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_fire && mask_rest == '0) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Store port and handshake outputs.
  always_comb begin
    s_tready = 1'b0;
    ram_we   = 1'b0;
    ram_addr = cell_addr({1'b0, in_x}, {1'b0, in_y}, {1'b0, in_z});
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        ram_we   = s_tvalid && in_op == OP_WRITE && in_inside;
      end
      ST_GATHER: ram_addr = cell_addr(nb_x, nb_y, nb_z);
      ST_EMIT:   ram_addr = cell_addr({1'b0, cx}, {1'b0, cy}, {1'b0, cz});
      default:   ram_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      vertex_counter <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      state <= state_next;
      if (emit_fire) begin
        m_tvalid       <= 1'b1;
        vertex_counter <= vertex_counter + VERTS_PER_FACE;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (in_accept && in_op == OP_RESTART) begin
        vertex_counter <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      cx       <= in_x;
      cy       <= in_y;
      cz       <= in_z;
      step     <= '0;
      face_air <= '0;
      rd_in    <= 1'b1;
    end
    if (state == ST_GATHER) begin
      step     <= step + 3'd1;
      rd_in    <= nb_in;
      face_air <= gather_mask;
    end
    if (emit_fire) begin
      face_air         <= mask_rest;
      face_x           <= cx;
      face_y           <= cy;
      face_z           <= cz;
      face_dir         <= pick;
      base_vertex      <= vertex_counter;
      reversed_winding <= pick[0];
      m_tlast          <= (mask_rest == '0);
    end
  end

  assign m_tdata = {7'b0, reversed_winding, base_vertex, face_dir, face_z, face_y, face_x};

endmodule
`default_nettype wire

### tb/voxel_face_culling_mesher_tb.sv
// Self-checking testbench for the voxel face culling mesher.
`timescale 1ns / 100ps
module voxel_face_culling_mesher_tb;
  import vfcm_pkg::*;

  localparam int EDGE          = 16;
  localparam int STORE_CELLS   = EDGE * EDGE * EDGE;
  localparam int IDLE_PCT      = 28;
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_GOAL   = 175;
  localparam int PRESSURE_AT   = 80;
  localparam int CALM_MESHES   = 20;
  localparam int DRAIN_CYCLES  = 30;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]         op;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [ID_W-1:0]    id;
  } request_t;

  typedef struct packed {
    logic               reversed;
    logic [VTX_W-1:0]   base;
    logic [DIR_W-1:0]   dir;
    logic [COORD_W-1:0] z;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } face_data_t;

  typedef struct packed {
    logic       last;
    face_data_t data;
  } face_t;

  // A row with typed set carries its faces as a direction mask and the first base vertex.
  typedef struct packed {
    request_t           req;
    logic               typed;
    logic [FACE_COUNT-1:0] mask;
    logic [VTX_W-1:0]   base;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // cell_x, cell_y, cell_z, block_id, zero fill
  logic [1:0]  s_tuser = '0;   // operation
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // face_x, face_y, face_z, face_dir, base_vertex,
                               // reversed_winding, zero fill
  logic        m_tlast;        // last_face

  logic [ID_W-1:0]  voxel_mem [STORE_CELLS];
  bit               written [STORE_CELLS];
  logic [VTX_W-1:0] vertex_count = '0;
  face_t            predicted_faces[$];
  face_t            face_queue[$];

  int error_count    = 0;
  int requests_sent  = 0;
  int stalled_cycles = 0;
  int hold_left      = 0;
  bit hold_req       = 1'b0;
  bit calm           = 1'b0;
  logic [COORD_W-1:0] cluster_x = '0, cluster_y = '0, cluster_z = '0;

  stim_row_t directed_rows [25] = '{
    // Isolated solid cell in the low corner, right after reset.
    '{'{OP_WRITE,   4'd1,  4'd0,  4'd0,  8'h00}, 1'b0, 6'b000000, 17'd0},
    '{'{OP_WRITE,   4'd0,  4'd1,  4'd0,  8'h00}, 1'b0, 6'b000000, 17'd0},
    '{'{OP_WRITE,   4'd0,  4'd0,  4'd1,  8'h00}, 1'b0, 6'b000000, 17'd0},
    '{'{OP_WRITE,   4'd0,  4'd0,  4'd0,  8'hFF}, 1'b0, 6'b000000, 17'd0},
    '{'{OP_MESH,    4'd0,  4'd0,  4'd0,  8'h00}, 1'b1, 6'b111111, 17'd0},
    '{'{OP_RESTART, 4'd0,  4'd0,  4'd0,  8'h00}, 1'b0, 6'b000000, 17'd0},
    '{'{OP_WRITE,   4'd0,  4'd0,  4'd1,  8'h01}, 1'b0, 6'b000000, 17'd0},
    '{'{OP_MESH,    4'd0,  4'd0,  4'd0,  8'h00}, 1'b1, 6'b111110, 17'd0},
    // High corner: air first, then solid with only the outward faces open.
    '{'{OP_WRITE,   4'd14, 4'd15, 4'd15, 8'hAA}, 1'b0, 6'b000000, 17'd0},
    '{'{OP_WRITE,   4'd15, 4'd14, 4'd15, 8'h55}, 1'b0, 6'b000000, 17'd0},
    '{'{OP_WRITE,   4'd15, 4'd15, 4'd14, 8'h80}, 1'b0, 6'b000000, 17'd0},
    '{'{OP_WRITE,   4'd15, 4'd15, 4'd15, 8'h00}, 1'b0, 6'b000000, 17'd0},
    '{'{OP_MESH,    4'd15, 4'd15, 4'd15, 8'hFF}, 1'b1, 6'b000000, 17'd0},
    '{'{OP_WRITE,   4'd15, 4'd15, 4'd15, 8'h7F}, 1'b0, 6'b000000, 17'd0},
    '{'{OP_MESH,    4'd15, 4'd15, 4'd15, 8'h00}, 1'b1, 6'b010101, 17'd20},
    // Interior cell buried in solid neighbours.
    '{'{OP_WRITE,   4'd5,  4'd10, 4'd7,  8'h01}, 1'b0, 6'b000000, 17'd0},
    '{'{OP_WRITE,   4'd5,  4'd10, 4'd5,  8'h02}, 1'b0, 6'b000000, 17'd0},
    '{'{OP_WRITE,   4'd6,  4'd10, 4'd6,  8'h04}, 1'b0, 6'b000000, 17'd0},
    '{'{OP_WRITE,   4'd4,  4'd10, 4'd6,  8'h08}, 1'b0, 6'b000000, 17'd0},
    '{'{OP_WRITE,   4'd5,  4'd11, 4'd6,  8'h10}, 1'b0, 6'b000000, 17'd0},
    '{'{OP_WRITE,   4'd5,  4'd9,  4'd6,  8'h20}, 1'b0, 6'b000000, 17'd0},
    '{'{OP_WRITE,   4'd5,  4'd10, 4'd6,  8'h40}, 1'b0, 6'b000000, 17'd0},
    '{'{OP_MESH,    4'd5,  4'd10, 4'd6,  8'h00}, 1'b1, 6'b000000, 17'd0},
    '{'{OP_UNUSED,  4'd15, 4'd0,  4'd15, 8'hFF}, 1'b1, 6'b000000, 17'd0},
    // The buried cell must have left the counter alone.
    '{'{OP_MESH,    4'd15, 4'd15, 4'd15, 8'h00}, 1'b0, 6'b000000, 17'd0}
  };

  voxel_face_culling_mesher #(
    .EDGE_CELLS(EDGE)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #2 clk = ~clk;

  function automatic bit in_store(input int x, input int y, input int z);
    return x >= 0 && x < EDGE && y >= 0 && y < EDGE && z >= 0 && z < EDGE;
  endfunction

  function automatic int cell_addr(input int x, input int y, input int z);
    return (z * EDGE + y) * EDGE + x;
  endfunction

  function automatic logic [ID_W-1:0] voxel_at(input int x, input int y, input int z);
    if (!in_store(x, y, z)) return '0;
    return voxel_mem[cell_addr(x, y, z)];
  endfunction

  function automatic logic [ID_W-1:0] random_id();
    if ($urandom_range(1) == 0) return '0;
    return ID_W'($urandom_range(255, 1));
  endfunction

  function automatic request_t random_request(input logic [1:0] op);
    request_t r;
    r.op = op;
    r.x  = COORD_W'($urandom_range(15));
    r.y  = COORD_W'($urandom_range(15));
    r.z  = COORD_W'($urandom_range(15));
    r.id = ID_W'($urandom_range(255));
    return r;
  endfunction

  task automatic step_toward(input int d, inout int x, inout int y, inout int z);
    case (d)
      FACE_POS_Z: z = z + 1;
      FACE_NEG_Z: z = z - 1;
      FACE_POS_X: x = x + 1;
      FACE_NEG_X: x = x - 1;
      FACE_POS_Y: y = y + 1;
      FACE_NEG_Y: y = y - 1;
      default: ;
    endcase
  endtask

  // Updates the store and counter copies and lists the exposed faces of a mesh request.
  task automatic predict_request(input request_t r);
    int    nx, ny, nz;
    face_t rec;
    predicted_faces.delete();
    case (r.op)
      OP_WRITE: begin
        if (in_store(r.x, r.y, r.z)) begin
          voxel_mem[cell_addr(r.x, r.y, r.z)] = r.id;
          written[cell_addr(r.x, r.y, r.z)] = 1'b1;
        end
      end
      OP_RESTART: vertex_count = '0;
      OP_MESH: begin
        if (voxel_at(r.x, r.y, r.z) != '0) begin
          for (int d = 0; d < FACE_COUNT; d++) begin
            nx = r.x;
            ny = r.y;
            nz = r.z;
            step_toward(d, nx, ny, nz);
            if (voxel_at(nx, ny, nz) == '0) begin
              rec.last          = 1'b0;
              rec.data.x        = r.x;
              rec.data.y        = r.y;
              rec.data.z        = r.z;
              rec.data.dir      = d[DIR_W-1:0];
              rec.data.base     = vertex_count;
              rec.data.reversed = d[0];
              predicted_faces.insert(predicted_faces.size(), rec);
              vertex_count = vertex_count + VERTS_PER_FACE;
            end
          end
          if (predicted_faces.size() > 0)
            predicted_faces[predicted_faces.size() - 1].last = 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  task automatic issue(input request_t r, input logic typed,
                       input logic [FACE_COUNT-1:0] mask, input logic [VTX_W-1:0] base);
    face_t            rec;
    logic [VTX_W-1:0] vtx;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= r.op;
    s_tdata  <= {4'b0, r.id, r.z, r.y, r.x};
    do @(posedge clk); while (!s_tready);
    predict_request(r);
    if (!typed) begin
      foreach (predicted_faces[i]) face_queue.insert(face_queue.size(), predicted_faces[i]);
    end else begin
      vtx = base;
      for (int d = 0; d < FACE_COUNT; d++) begin
        if (mask[d]) begin
          rec.data.x        = r.x;
          rec.data.y        = r.y;
          rec.data.z        = r.z;
          rec.data.dir      = d[DIR_W-1:0];
          rec.data.base     = vtx;
          rec.data.reversed = d[0];
          rec.last          = (mask >> (d + 1)) == '0;
          face_queue.insert(face_queue.size(), rec);
          vtx = vtx + VERTS_PER_FACE;
        end
      end
    end
    if (r.op != OP_UNUSED) requests_sent++;
  endtask

  // Writes any unwritten cell among the target and its neighbours, then meshes the target.
  task automatic mesh_with_neighbours(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                                      input logic [COORD_W-1:0] z);
    int       nx, ny, nz;
    request_t r;
    for (int d = -1; d < FACE_COUNT; d++) begin
      nx = x;
      ny = y;
      nz = z;
      if (d >= 0) step_toward(d, nx, ny, nz);
      if (in_store(nx, ny, nz) && !written[cell_addr(nx, ny, nz)]) begin
        r.op = OP_WRITE;
        r.x  = nx[COORD_W-1:0];
        r.y  = ny[COORD_W-1:0];
        r.z  = nz[COORD_W-1:0];
        r.id = random_id();
        issue(r, 1'b0, '0, '0);
      end
    end
    r.op = OP_MESH;
    r.x  = x;
    r.y  = y;
    r.z  = z;
    r.id = ID_W'($urandom_range(255));
    issue(r, 1'b0, '0, '0);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : result_sink
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin : face_monitor
    face_data_t got;
    face_t      want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[32:0];
      if (face_queue.size() == 0) begin
        $display("%0t: unexpected face transfer, expected none, actual tdata %h tlast %b",
                 $time, m_tdata, m_tlast);
        error_count++;
      end else begin
        want = face_queue.pop_front();
        check_field("face_x", want.data.x, got.x);
        check_field("face_y", want.data.y, got.y);
        check_field("face_z", want.data.z, got.z);
        check_field("face_dir", want.data.dir, got.dir);
        check_field("base_vertex", want.data.base, got.base);
        check_field("reversed_winding", want.data.reversed, got.reversed);
        check_field("last_face", want.last, m_tlast);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stalled_cycles = 0;
    end else begin
      stalled_cycles++;
      if (stalled_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    request_t r;
    int       pick;
    int       random_goal;
    bit       pressure_done;
    pressure_done = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      issue(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].mask,
            directed_rows[i].base);

    // Mesh a fully exposed cell back to back, with no idling on either side.
    calm = 1'b1;
    r = '{OP_WRITE, 4'd0, 4'd0, 4'd1, 8'h00};
    issue(r, 1'b0, '0, '0);
    r = '{OP_MESH, 4'd0, 4'd0, 4'd0, 8'h00};
    repeat (CALM_MESHES) issue(r, 1'b0, '0, '0);
    calm = 1'b0;

    random_goal = requests_sent + RANDOM_GOAL;
    while (requests_sent < random_goal) begin
      if (!pressure_done && requests_sent + RANDOM_GOAL - random_goal >= PRESSURE_AT) begin
        hold_req      = 1'b1;
        pressure_done = 1'b1;
      end
      if ($urandom_range(9) == 0) begin
        cluster_x = 4'($urandom_range(2) * 6);
        cluster_y = 4'($urandom_range(2) * 6);
        cluster_z = 4'($urandom_range(2) * 6);
      end
      pick = $urandom_range(99);
      if (pick < 62) begin
        // Most meshes stay in a small cluster so neighbours are often solid.
        if ($urandom_range(3) != 0)
          mesh_with_neighbours(cluster_x + 4'($urandom_range(3)),
                               cluster_y + 4'($urandom_range(3)),
                               cluster_z + 4'($urandom_range(3)));
        else
          mesh_with_neighbours(4'($urandom_range(15)), 4'($urandom_range(15)),
                               4'($urandom_range(15)));
      end else if (pick < 84) begin
        r.op = OP_WRITE;
        r.x  = cluster_x + 4'($urandom_range(3));
        r.y  = cluster_y + 4'($urandom_range(3));
        r.z  = cluster_z + 4'($urandom_range(3));
        r.id = random_id();
        issue(r, 1'b0, '0, '0);
      end else if (pick < 94) begin
        r = random_request(OP_RESTART);
        issue(r, 1'b0, '0, '0);
      end else begin
        r = random_request(OP_UNUSED);
        issue(r, 1'b0, '0, '0);
      end
    end
    s_tvalid <= 1'b0;

    while (face_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
